FILE: rtl/core/mil_pkg.sv
package mil_pkg;

   localparam int AES_ROUNDS = 10;

   typedef enum logic [1:0] {
      ACT_F1      = 2'd0,
      ACT_F1_STAR = 2'd1,
      ACT_F2345   = 2'd2,
      ACT_F5_STAR = 2'd3
   } action_type;

   localparam logic CSR_OP_HIGH = 1'b0;
   localparam logic CSR_OP_LOW  = 1'b1;

   localparam logic [63:0] OP_HIGH_RESET = 64'h63BFA50EE6523365;
   localparam logic [63:0] OP_LOW_RESET  = 64'hFF14C1F45F88737D;

   // Milenage constants c2..c5 (c1 is zero) and rotations in bytes.
   localparam logic [7:0] MIL_C2 = 8'h01;
   localparam logic [7:0] MIL_C3 = 8'h02;
   localparam logic [7:0] MIL_C4 = 8'h04;
   localparam logic [7:0] MIL_C5 = 8'h08;
   localparam int MIL_R1 = 8;
   localparam int MIL_R3 = 4;
   localparam int MIL_R4 = 8;
   localparam int MIL_R5 = 12;

   localparam logic [7:0] RCON [AES_ROUNDS] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
   };

   localparam logic [7:0] SBOX_TABLE [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
   endfunction

   // Byte k of a 128-bit block sits at bits [127-8k -: 8].
   function automatic logic [127:0] aes_round(logic [127:0] s, logic [127:0] rk, logic last);
      logic [7:0] u [16];
      logic [7:0] m [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] res;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            u[r + 4 * c] = SBOX_TABLE[s[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = u[4 * c];
         a1 = u[4 * c + 1];
         a2 = u[4 * c + 2];
         a3 = u[4 * c + 3];
         all = a0 ^ a1 ^ a2 ^ a3;
         m[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
         m[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
         m[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
         m[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      for (int i = 0; i < 16; i++) begin
         res[127 - 8 * i -: 8] = last ? u[i] : m[i];
      end
      return res ^ rk;
   endfunction

   function automatic logic [127:0] key_step(logic [127:0] rk, logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = rk[127:96] ^ 32'h0;
      t = {SBOX_TABLE[rk[23:16]] ^ rcon, SBOX_TABLE[rk[15:8]],
           SBOX_TABLE[rk[7:0]], SBOX_TABLE[rk[31:24]]};
      w0 = w0 ^ t;
      w1 = rk[95:64] ^ w0;
      w2 = rk[63:32] ^ w1;
      w3 = rk[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // Rotation toward byte 0 by a constant number of bytes.
   function automatic logic [127:0] rot_bytes(logic [127:0] x, int n);
      return (x << (8 * n)) | (x >> (128 - 8 * n));
   endfunction

endpackage

FILE: rtl/core/milenage_auth_functions_unit.sv
// Channel   | Direction | Transfer condition      | Contents
// ----------+-----------+-------------------------+----------------------------------
// request   | in        | start && !busy          | req_action, key, RAND, SQN, AMF
// response  | out       | rsp_valid (one cycle)   | MAC/RES, CK, IK, AK
// csr write | in        | csr_valid && csr_ready  | csr_index, csr_data (OP halves)
//
// A request is accepted every cycle while busy is low; its response passes
// through three unrolled AES-128 cores of ten round stages each
// (OPc, TEMP, then three output lanes side by side) plus one output register.
// Reset is synchronous, clears the valid bits and loads the OP registers with
// their reset values; busy is high only while reset is held. The receiver cannot stall, so the
// pipeline never holds and csr_ready is always high.
module milenage_auth_functions_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_action,
   input  logic [63:0]  req_key_high,
   input  logic [63:0]  req_key_low,
   input  logic [63:0]  req_rand_high,
   input  logic [63:0]  req_rand_low,
   input  logic [47:0]  req_seq_number,
   input  logic [15:0]  req_auth_field,
   output logic         rsp_valid,
   output logic [63:0]  rsp_mac_or_res,
   output logic [63:0]  rsp_ck_high,
   output logic [63:0]  rsp_ck_low,
   output logic [63:0]  rsp_ik_high,
   output logic [63:0]  rsp_ik_low,
   output logic [47:0]  rsp_anon_key,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [63:0]  csr_data
);

   localparam int LATENCY = 3 * mil_pkg::AES_ROUNDS + 1;

   // Side information carried with each item through each AES phase.
   typedef struct packed {
      mil_pkg::action_type action;
      logic [127:0]        rand_val;
      logic [47:0]         sqn;
      logic [15:0]         amf;
   } side_a_type;

   typedef struct packed {
      mil_pkg::action_type action;
      logic [47:0]         sqn;
      logic [15:0]         amf;
      logic [127:0]        opc;
   } side_b_type;

   typedef struct packed {
      mil_pkg::action_type action;
      logic [127:0]        opc;
   } side_c_type;

   logic [63:0] op_high_ff, op_low_ff;
   logic [127:0] op_val;
   logic         accept;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign op_val    = {op_high_ff, op_low_ff};

   // The user must rewrite OP only while no item is in flight, so every stage may
   // read the registers directly; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_high_ff <= mil_pkg::OP_HIGH_RESET;
         op_low_ff  <= mil_pkg::OP_LOW_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mil_pkg::CSR_OP_HIGH: op_high_ff <= csr_data;
            mil_pkg::CSR_OP_LOW:  op_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Phase A: E_K(OP).
   side_a_type   a_side_in, a_side_out;
   logic [127:0] a_block_in [1];
   logic [127:0] a_block_out [1];
   logic [127:0] a_key_out;
   logic         a_valid_out;

   assign a_side_in.action   = mil_pkg::action_type'(req_action);
   assign a_side_in.rand_val = {req_rand_high, req_rand_low};
   assign a_side_in.sqn      = req_seq_number;
   assign a_side_in.amf      = req_auth_field;
   assign a_block_in[0]      = op_val;

   mil_aes_pipe #(.LANES(1), .SIDE_W($bits(side_a_type))) u_phase_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_key    ({req_key_high, req_key_low}),
      .in_block  (a_block_in),
      .in_side   (a_side_in),
      .out_valid (a_valid_out),
      .out_key   (a_key_out),
      .out_block (a_block_out),
      .out_side  (a_side_out)
   );

   // Phase B: TEMP = E_K(RAND xor OPc).
   side_b_type   b_side_in, b_side_out;
   logic [127:0] b_block_in [1];
   logic [127:0] b_block_out [1];
   logic [127:0] b_key_out;
   logic         b_valid_out;

   assign b_side_in.action = a_side_out.action;
   assign b_side_in.sqn    = a_side_out.sqn;
   assign b_side_in.amf    = a_side_out.amf;
   assign b_side_in.opc    = a_block_out[0] ^ op_val;
   assign b_block_in[0]    = a_side_out.rand_val ^ b_side_in.opc;

   mil_aes_pipe #(.LANES(1), .SIDE_W($bits(side_b_type))) u_phase_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_out),
      .in_key    (a_key_out),
      .in_block  (b_block_in),
      .in_side   (b_side_in),
      .out_valid (b_valid_out),
      .out_key   (b_key_out),
      .out_block (b_block_out),
      .out_side  (b_side_out)
   );

   // Phase C: the output functions. Lane 0 serves f1, f1*, f2/f5 and f5*;
   // lanes 1 and 2 serve f3 and f4.
   side_c_type   c_side_in, c_side_out;
   logic [127:0] c_block_in [3];
   logic [127:0] c_block_out [3];
   logic         c_valid_out;
   logic [127:0] temp_val, x_val, in1_val, f1_val, c_lane0_in;

   assign temp_val = b_block_out[0];
   assign x_val    = temp_val ^ b_side_out.opc;
   assign in1_val  = {b_side_out.sqn, b_side_out.amf, b_side_out.sqn, b_side_out.amf};
   assign f1_val   = mil_pkg::rot_bytes(in1_val ^ b_side_out.opc, mil_pkg::MIL_R1) ^ temp_val;

   assign c_side_in.action = b_side_out.action;
   assign c_side_in.opc    = b_side_out.opc;

   always_comb begin
      case (b_side_out.action)
         mil_pkg::ACT_F1, mil_pkg::ACT_F1_STAR: c_lane0_in = f1_val;
         mil_pkg::ACT_F2345: c_lane0_in = x_val ^ {120'h0, mil_pkg::MIL_C2};
         default: c_lane0_in = mil_pkg::rot_bytes(x_val, mil_pkg::MIL_R5)
                               ^ {120'h0, mil_pkg::MIL_C5};
      endcase
   end
   assign c_block_in[0] = c_lane0_in;
   assign c_block_in[1] = mil_pkg::rot_bytes(x_val, mil_pkg::MIL_R3) ^ {120'h0, mil_pkg::MIL_C3};
   assign c_block_in[2] = mil_pkg::rot_bytes(x_val, mil_pkg::MIL_R4) ^ {120'h0, mil_pkg::MIL_C4};

   mil_aes_pipe #(.LANES(3), .SIDE_W($bits(side_c_type))) u_phase_c (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_out),
      .in_key    (b_key_out),
      .in_block  (c_block_in),
      .in_side   (c_side_in),
      .out_valid (c_valid_out),
      .out_key   (),
      .out_block (c_block_out),
      .out_side  (c_side_out)
   );

   // Output register: select the fields for the action, zero the rest.
   logic [127:0] o0, o1, o2;
   logic         rsp_valid_ff;
   logic [63:0]  mac_ff, mac_in, ck_high_ff, ck_high_in, ck_low_ff, ck_low_in;
   logic [63:0]  ik_high_ff, ik_high_in, ik_low_ff, ik_low_in;
   logic [47:0]  ak_ff, ak_in;

   assign o0 = c_block_out[0] ^ c_side_out.opc;
   assign o1 = c_block_out[1] ^ c_side_out.opc;
   assign o2 = c_block_out[2] ^ c_side_out.opc;

   always_comb begin
      mac_in     = '0;
      ck_high_in = '0;
      ck_low_in  = '0;
      ik_high_in = '0;
      ik_low_in  = '0;
      ak_in      = '0;
      case (c_side_out.action)
         mil_pkg::ACT_F1:      mac_in = o0[127:64];
         mil_pkg::ACT_F1_STAR: mac_in = o0[63:0];
         mil_pkg::ACT_F2345: begin
            mac_in     = o0[63:0];
            ak_in      = o0[127:80];
            ck_high_in = o1[127:64];
            ck_low_in  = o1[63:0];
            ik_high_in = o2[127:64];
            ik_low_in  = o2[63:0];
         end
         default: ak_in = o0[127:80];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= c_valid_out;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff     <= mac_in;
      ck_high_ff <= ck_high_in;
      ck_low_ff  <= ck_low_in;
      ik_high_ff <= ik_high_in;
      ik_low_ff  <= ik_low_in;
      ak_ff      <= ak_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mac_or_res = mac_ff;
   assign rsp_ck_high    = ck_high_ff;
   assign rsp_ck_low     = ck_low_ff;
   assign rsp_ik_high    = ik_high_ff;
   assign rsp_ik_low     = ik_low_ff;
   assign rsp_anon_key   = ak_ff;

   // Every accepted request produces a response on rsp_valid.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted request did not produce a response");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without a matching request");

   // The resync AK action produces nothing but the anonymity key.
   a_f5s_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_action, LATENCY) == mil_pkg::ACT_F5_STAR)
      |-> (rsp_mac_or_res == 64'h0 && rsp_ck_high == 64'h0 && rsp_ik_low == 64'h0))
      else $error("f5 star response carries nonzero unused fields");

endmodule

FILE: rtl/core/mil_aes_pipe.sv
// Unrolled AES-128 encryption, one round per register stage. The key
// schedule advances alongside, shared by all lanes. The cipher key itself
// also travels with the item and leaves on out_key, so the next core can
// expand it again from the start.
module mil_aes_pipe #(
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [127:0]        in_key,
   input  logic [127:0]        in_block [LANES],
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [127:0]        out_key,
   output logic [127:0]        out_block [LANES],
   output logic [SIDE_W-1:0]   out_side
);

   localparam int ROUNDS = mil_pkg::AES_ROUNDS;

   logic                valid_ff [ROUNDS];
   logic [127:0]        key_ff   [ROUNDS];
   logic [127:0]        base_ff  [ROUNDS];
   logic [127:0]        state_ff [ROUNDS][LANES];
   logic [SIDE_W-1:0]   side_ff  [ROUNDS];

   for (genvar g = 0; g < ROUNDS; g++) begin : g_round
      logic                valid_prev;
      logic [127:0]        key_prev;
      logic [127:0]        key_in;
      logic [127:0]        base_prev;
      logic [SIDE_W-1:0]   side_prev;
      logic [127:0]        st_prev [LANES];
      logic [127:0]        st_in   [LANES];

      if (g == 0) begin : g_first
         assign valid_prev = in_valid;
         assign key_prev   = in_key;
         assign base_prev  = in_key;
         assign side_prev  = in_side;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign st_prev[l] = in_block[l] ^ in_key;
         end
      end else begin : g_next
         assign valid_prev = valid_ff[g-1];
         assign key_prev   = key_ff[g-1];
         assign base_prev  = base_ff[g-1];
         assign side_prev  = side_ff[g-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign st_prev[l] = state_ff[g-1][l];
         end
      end

      assign key_in = mil_pkg::key_step(key_prev, mil_pkg::RCON[g]);
      for (genvar l = 0; l < LANES; l++) begin : g_calc
         assign st_in[l] = mil_pkg::aes_round(st_prev[l], key_in, (g == ROUNDS - 1));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         key_ff[g]  <= key_in;
         base_ff[g] <= base_prev;
         side_ff[g] <= side_prev;
         for (int l = 0; l < LANES; l++) begin
            state_ff[g][l] <= st_in[l];
         end
      end
   end

   assign out_valid = valid_ff[ROUNDS-1];
   assign out_key   = base_ff[ROUNDS-1];
   assign out_side  = side_ff[ROUNDS-1];
   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_block[l] = state_ff[ROUNDS-1][l];
   end

endmodule
